// ===== src/dtq_pkg.sv =====
// Package for the delta timer queue: sizes, beat types, status codes, control interface types.
package dtq_pkg;

	localparam int TIMER_ENTRIES = 16;
	localparam int DELAY_BITS    = 24;
	localparam int OWNER_BITS    = 8;
	localparam int MAX_RESULTS   = 16;

	localparam int IDX_W = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TIMER_ENTRIES + 1);
	localparam int RES_W = $clog2(MAX_RESULTS + 1);

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [RES_W-1:0]      res_cnt_t;
	typedef logic [DELAY_BITS-1:0] delay_t;
	typedef logic [OWNER_BITS-1:0] owner_t;

	typedef enum logic [1:0] {
		STATUS_NONE    = 2'd0,
		STATUS_ADDED   = 2'd1,
		STATUS_FULL    = 2'd2,
		STATUS_EXPIRED = 2'd3
	} status_t;

	typedef enum logic {
		FUNC_TICK = 1'b0,
		FUNC_ADD  = 1'b1
	} func_t;

	typedef struct packed {
		logic                  func;
		owner_t                owner_id;
		delay_t                delay;
	} item_t;

	typedef struct packed {
		logic [1:0]            status;
		owner_t                expired_owner;
		logic                  last;
	} result_t;

	typedef enum logic [2:0] {
		OP_IDLE   = 3'd0,
		OP_ACCEPT = 3'd1,
		OP_WALK   = 3'd2,
		OP_LINK1  = 3'd3,
		OP_LINK2  = 3'd4,
		OP_DEC    = 3'd5,
		OP_CHECK  = 3'd6
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic tick_idle;
		logic walk_go;
		logic expire;
	} stat_t;

endpackage

// ===== src/dtq_ctrl.sv =====
// Controller state machine for the delta timer queue.
module dtq_ctrl import dtq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  func,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_WALK  = 6'b000010,
		S_LINK1 = 6'b000100,
		S_LINK2 = 6'b001000,
		S_DEC   = 6'b010000,
		S_CHECK = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_IDLE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = OP_ACCEPT;
					if (func == FUNC_ADD) begin
						state_d = stat.full ? S_IDLE : S_WALK;
					end else begin
						state_d = stat.tick_idle ? S_IDLE : S_DEC;
					end
				end
			end
			S_WALK: begin
				cmd.op = OP_WALK;
				if (!stat.walk_go) state_d = S_LINK1;
			end
			S_LINK1: begin
				cmd.op  = OP_LINK1;
				state_d = S_LINK2;
			end
			S_LINK2: begin
				cmd.op  = OP_LINK2;
				state_d = S_IDLE;
			end
			S_DEC: begin
				cmd.op  = OP_DEC;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.op = OP_CHECK;
				if (!stat.expire) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== src/dtq_datapath.sv =====
// Datapath of the delta timer queue: entry pool, list pointers, walk registers, result register.
module dtq_datapath import dtq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  item_t   item,
	output stat_t   stat,
	output result_t result,
	output logic    result_valid
);

	delay_t entry_delta_q [TIMER_ENTRIES];
	owner_t entry_owner_q [TIMER_ENTRIES];
	idx_t   entry_link_q  [TIMER_ENTRIES];

	idx_t     free_head_q, queue_head_q, fresh_q, cur_q, prev_q;
	cnt_t     free_count_q, len_q, walk_cnt_q;
	logic     nonempty_q, has_cur_q, has_prev_q, pend_v_q, result_valid_q;
	delay_t   d_q;
	owner_t   pend_owner_q;
	res_cnt_t exp_cnt_q;
	result_t  result_q;

	idx_t   rd_idx;
	delay_t rd_delta;
	owner_t rd_owner;
	idx_t   rd_link;

	logic   delta_we, link_we;
	idx_t   delta_wa, link_wa;
	delay_t delta_wd;
	idx_t   link_wd;

	cnt_t   len_new;
	delay_t d_new;

	// one shared read address for all three arrays
	always_comb begin
		case (cmd.op)
			OP_WALK, OP_LINK1, OP_LINK2: rd_idx = cur_q;
			OP_DEC, OP_CHECK:            rd_idx = queue_head_q;
			default:                     rd_idx = free_head_q;
		endcase
	end

	assign rd_delta = entry_delta_q[rd_idx];
	assign rd_owner = entry_owner_q[rd_idx];
	assign rd_link  = entry_link_q[rd_idx];

	assign len_new = cnt_t'(TIMER_ENTRIES) - free_count_q;
	assign d_new   = (item.delay == '0) ? delay_t'(1) : item.delay;

	assign stat.full      = (free_count_q == '0);
	assign stat.tick_idle = !nonempty_q || (free_count_q >= cnt_t'(TIMER_ENTRIES));
	assign stat.walk_go   = has_cur_q && (d_q > rd_delta);
	assign stat.expire    = (exp_cnt_q < res_cnt_t'(MAX_RESULTS)) && nonempty_q
	                        && (rd_delta == '0);

	// single write port per array
	always_comb begin
		delta_we = 1'b0;
		delta_wa = fresh_q;
		delta_wd = d_q;
		link_we  = 1'b0;
		link_wa  = fresh_q;
		link_wd  = has_cur_q ? cur_q : '0;
		case (cmd.op)
			OP_LINK1: begin
				delta_we = 1'b1;
				link_we  = 1'b1;
			end
			OP_LINK2: begin
				delta_we = has_cur_q;
				delta_wa = cur_q;
				delta_wd = rd_delta - d_q;
				link_we  = has_prev_q;
				link_wa  = prev_q;
				link_wd  = fresh_q;
			end
			OP_DEC: begin
				delta_we = (rd_delta != '0);
				delta_wa = queue_head_q;
				delta_wd = rd_delta - delay_t'(1);
			end
			OP_CHECK: begin
				// return the expiring head to the free list
				link_we = stat.expire;
				link_wa = queue_head_q;
				link_wd = free_head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (delta_we) entry_delta_q[delta_wa] <= delta_wd;
		if (cmd.op == OP_ACCEPT && item.func == FUNC_ADD && !stat.full) begin
			entry_owner_q[free_head_q] <= item.owner_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMER_ENTRIES; i++) begin
				entry_link_q[i] <= idx_t'((i + 1) % TIMER_ENTRIES);
			end
		end else if (link_we) begin
			entry_link_q[link_wa] <= link_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q    <= '0;
			free_count_q   <= cnt_t'(TIMER_ENTRIES);
			queue_head_q   <= '0;
			nonempty_q     <= 1'b0;
			fresh_q        <= '0;
			cur_q          <= '0;
			prev_q         <= '0;
			len_q          <= '0;
			walk_cnt_q     <= '0;
			has_cur_q      <= 1'b0;
			has_prev_q     <= 1'b0;
			d_q            <= '0;
			pend_v_q       <= 1'b0;
			pend_owner_q   <= '0;
			exp_cnt_q      <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			case (cmd.op)
				OP_ACCEPT: begin
					if (item.func == FUNC_ADD) begin
						if (stat.full) begin
							result_valid_q <= 1'b1;
							result_q       <= '{STATUS_FULL, '0, 1'b1};
						end else begin
							// pop the free head, then start the walk at the queue head
							fresh_q      <= free_head_q;
							free_head_q  <= rd_link;
							free_count_q <= free_count_q - cnt_t'(1);
							len_q        <= len_new;
							d_q          <= d_new;
							cur_q        <= queue_head_q;
							has_cur_q    <= nonempty_q && (len_new != '0);
							has_prev_q   <= 1'b0;
							walk_cnt_q   <= '0;
						end
					end else begin
						if (stat.tick_idle) begin
							result_valid_q <= 1'b1;
							result_q       <= '{STATUS_NONE, '0, 1'b1};
						end
						exp_cnt_q <= '0;
						pend_v_q  <= 1'b0;
					end
				end
				OP_WALK: begin
					if (stat.walk_go) begin
						d_q        <= d_q - rd_delta;
						prev_q     <= cur_q;
						has_prev_q <= 1'b1;
						walk_cnt_q <= walk_cnt_q + cnt_t'(1);
						if ((walk_cnt_q + cnt_t'(1)) >= len_q) begin
							has_cur_q <= 1'b0;
						end else begin
							cur_q <= rd_link;
						end
					end
				end
				OP_LINK2: begin
					if (!has_prev_q) queue_head_q <= fresh_q;
					nonempty_q     <= 1'b1;
					result_valid_q <= 1'b1;
					result_q       <= '{STATUS_ADDED, '0, 1'b1};
				end
				OP_CHECK: begin
					// hold each expiry in a pending register so the final beat can carry last
					if (stat.expire) begin
						if (pend_v_q) begin
							result_valid_q <= 1'b1;
							result_q       <= '{STATUS_EXPIRED, pend_owner_q, 1'b0};
						end
						pend_v_q     <= 1'b1;
						pend_owner_q <= rd_owner;
						exp_cnt_q    <= exp_cnt_q + res_cnt_t'(1);
						free_head_q  <= queue_head_q;
						free_count_q <= free_count_q + cnt_t'(1);
						if ((free_count_q + cnt_t'(1)) >= cnt_t'(TIMER_ENTRIES)) begin
							nonempty_q   <= 1'b0;
							queue_head_q <= '0;
						end else begin
							queue_head_q <= rd_link;
						end
					end else begin
						result_valid_q <= 1'b1;
						if (pend_v_q) begin
							result_q <= '{STATUS_EXPIRED, pend_owner_q, 1'b1};
						end else begin
							result_q <= '{STATUS_NONE, '0, 1'b1};
						end
						pend_v_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

// ===== src/delta_timer_queue.sv =====
// Top level of the delta timer queue: controller and datapath.
//
//   channel   ports                       accepted when
//   item      start, busy, item           start && !busy at a rising edge
//   result    result_valid, result        result_valid high (one cycle per beat)
//
// Add: accept, then WALK past each queued entry whose delta is below the remaining delay,
// then LINK1 and LINK2; the result beat shows in the cycle after LINK2.
// Pool full or idle tick: the result beat shows the cycle after the accept.
// Tick: accept, DEC, then CHECK while expiries remain (at most MAX_RESULTS) and once more;
// expiry beats come one per cycle. busy is low again when the last beat shows.
// Reset clears the queue and rebuilds the free chain at once; no clearing pass.
// The receiver cannot stall: each result beat is valid for exactly one cycle.
module delta_timer_queue import dtq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output result_t result,
	output logic    result_valid
);

	cmd_t  cmd;
	stat_t stat;

	dtq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (item.func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	dtq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
